FILE: src/cplx_pkg.sv
// Shared types and constants of the charlieplex LED scanner.
package cplx_pkg;

  localparam int PIN_COUNT_W = 4;
  localparam int ON_TIME_W   = 16;
  localparam int LED_INDEX_W = 6;
  localparam int DRIVE_W     = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [PIN_COUNT_W-1:0] PIN_COUNT_RESET = 4'd8;
  localparam logic [ON_TIME_W-1:0]   ON_TIME_RESET   = 16'd500;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PIN_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ON_TIME   = 2'd1;

  typedef struct packed {
    logic [1:0]             kind;
    logic [LED_INDEX_W-1:0] led_index;
    logic                   led_on;
  } in_item_t;

  typedef struct packed {
    logic [DRIVE_W-1:0]     drive_enable;
    logic [DRIVE_W-1:0]     drive_high;
    logic [LED_INDEX_W-1:0] lit_led;
    logic                   lit_valid;
    logic                   rejected;
  } out_item_t;

endpackage

FILE: src/charlieplex_led_scanner_core.sv
// Charlieplexed LED matrix scanner: frame store, dwell timer and scan sequencer.
//
// Each input transfer yields exactly one result transfer. A frame write, a frame clear or
// an unused kind goes straight to the result state. A tick first passes the check state,
// which keeps the present LED driven while it stays lit and its dwell lasts; else it searches
// the n LEDs (n = pin_count times pin_count minus one): the sequencer walks the frame memory
// one LED per cycle through its single read port until it finds a lit LED or has checked all n.
// No input is taken while an item is in progress; after reset the frame reads as clear at once.
module charlieplex_led_scanner_core import cplx_pkg::*; #(
  parameter int MAX_PINS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MaxLeds   = MAX_PINS * (MAX_PINS - 1);
  localparam int LedW      = $clog2(MaxLeds);
  localparam int NW        = $clog2(MaxLeds + 1);
  localparam int PinW      = $clog2(MAX_PINS);
  localparam int CW        = (NW > LED_INDEX_W) ? NW : LED_INDEX_W;
  localparam int ResetPins = (int'(PIN_COUNT_RESET) > MAX_PINS) ? MAX_PINS
                                                                 : int'(PIN_COUNT_RESET);
  localparam int AdvW      = LedW + 2 * PinW;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CHK    = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]           state;
  logic [PinW-1:0]      per;
  logic [NW-1:0]        nleds;
  logic [ON_TIME_W-1:0] on_time;
  logic [MaxLeds-1:0]   valid;
  logic [LedW-1:0]      cur;
  logic [PinW-1:0]      cur_i;
  logic [PinW-1:0]      cur_j;
  logic [ON_TIME_W-1:0] dwell;
  logic                 active;
  logic                 rej;
  logic [LedW-1:0]      k;
  logic [PinW-1:0]      ki;
  logic [PinW-1:0]      kj;
  logic [NW-1:0]        cnt;
  logic                 pend;
  logic [LedW-1:0]      chk_k;
  logic [PinW-1:0]      chk_i;
  logic [PinW-1:0]      chk_j;
  logic                 vld_q;

  logic                 in_fire;
  logic [CW-1:0]        idx_ext;
  logic                 reject_now;
  logic                 ram_we;
  logic [LedW-1:0]      waddr;
  logic [LedW-1:0]      raddr;
  logic                 ram_q;
  logic                 bit_q;
  logic [ON_TIME_W-1:0] eff;
  logic                 hold;
  logic [PinW-1:0]      per_cfg;
  logic [NW-1:0]        nleds_cfg;
  logic [PinW-1:0]      sink;
  logic [CW-1:0]        cur_ext;
  logic [AdvW-1:0]      adv_cur;
  logic [AdvW-1:0]      adv_k;
  out_item_t            result;

  function automatic logic [AdvW-1:0] advance(
    input logic [LedW-1:0] k_in,
    input logic [PinW-1:0] i_in,
    input logic [PinW-1:0] j_in,
    input logic [NW-1:0]   n_in,
    input logic [PinW-1:0] per_in
  );
    logic [LedW-1:0] k_o;
    logic [PinW-1:0] i_o;
    logic [PinW-1:0] j_o;
    if (NW'(k_in) + NW'(1) == n_in) begin
      k_o = '0;
      i_o = '0;
      j_o = '0;
    end else begin
      k_o = k_in + LedW'(1);
      if (j_in + PinW'(1) == per_in) begin
        i_o = i_in + PinW'(1);
        j_o = '0;
      end else begin
        i_o = i_in;
        j_o = j_in + PinW'(1);
      end
    end
    return {k_o, i_o, j_o};
  endfunction

  assign in_ready   = (state == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign idx_ext    = CW'(in_data.led_index);
  assign reject_now = (idx_ext >= CW'(nleds));
  assign ram_we     = in_fire && (in_data.kind == KIND_WRITE) && !reject_now;
  assign waddr      = idx_ext[LedW-1:0];
  assign raddr      = (state == ST_SEARCH) ? k : cur;
  assign bit_q      = vld_q && ram_q;
  assign eff        = (on_time == '0) ? ON_TIME_W'(1) : on_time;
  assign hold       = active && bit_q && (dwell < eff);
  assign sink       = (cur_j >= cur_i) ? cur_j + PinW'(1) : cur_j;
  assign cur_ext    = CW'(cur);
  assign adv_cur    = advance(cur, cur_i, cur_j, nleds, per);
  assign adv_k      = advance(k, ki, kj, nleds, per);

  always_comb begin
    int pv;
    pv = int'(cfg_data[PIN_COUNT_W-1:0]);
    if (pv < 2) begin
      pv = 2;
    end
    if (pv > MAX_PINS) begin
      pv = MAX_PINS;
    end
    per_cfg   = PinW'(pv - 1);
    nleds_cfg = NW'(pv * (pv - 1));
  end

  always_comb begin
    result = '0;
    for (int b = 0; b < DRIVE_W; b++) begin
      if (active && (int'(cur_i) == b)) begin
        result.drive_enable[b] = 1'b1;
        result.drive_high[b]   = 1'b1;
      end
      if (active && (int'(sink) == b)) begin
        result.drive_enable[b] = 1'b1;
      end
    end
    result.lit_led   = active ? cur_ext[LED_INDEX_W-1:0] : '0;
    result.lit_valid = active;
    result.rejected  = rej;
  end

  cplx_ram #(
    .WIDTH(1),
    .DEPTH(MaxLeds)
  ) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(in_data.led_on),
    .raddr(raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    vld_q <= valid[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      per       <= PinW'(ResetPins - 1);
      nleds     <= NW'(ResetPins * (ResetPins - 1));
      on_time   <= ON_TIME_RESET;
      valid     <= '0;
      cur       <= '0;
      cur_i     <= '0;
      cur_j     <= '0;
      dwell     <= '0;
      active    <= 1'b0;
      rej       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            rej <= (in_data.kind == KIND_WRITE) && reject_now;
            if (ram_we) begin
              valid[waddr] <= 1'b1;
            end
            if (in_data.kind == KIND_CLEAR) begin
              valid <= '0;
            end
            state <= (in_data.kind == KIND_TICK) ? ST_CHK : ST_DONE;
          end
        end
        ST_CHK: begin
          cnt  <= '0;
          pend <= 1'b0;
          if (hold) begin
            dwell <= dwell + ON_TIME_W'(1);
            state <= ST_DONE;
          end else begin
            if (active) begin
              {k, ki, kj} <= adv_cur;
            end else begin
              k  <= cur;
              ki <= cur_i;
              kj <= cur_j;
            end
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (pend && bit_q) begin
            cur    <= chk_k;
            cur_i  <= chk_i;
            cur_j  <= chk_j;
            dwell  <= ON_TIME_W'(1);
            active <= 1'b1;
            state  <= ST_DONE;
          end else if (cnt == nleds) begin
            active <= 1'b0;
            dwell  <= '0;
            state  <= ST_DONE;
          end else begin
            chk_k       <= k;
            chk_i       <= ki;
            chk_j       <= kj;
            pend        <= 1'b1;
            {k, ki, kj} <= adv_k;
            cnt         <= cnt + NW'(1);
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_data  <= result;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cfg_we && (cfg_index == REG_PIN_COUNT)) begin
        per    <= per_cfg;
        nleds  <= nleds_cfg;
        valid  <= '0;
        cur    <= '0;
        cur_i  <= '0;
        cur_j  <= '0;
        dwell  <= '0;
        active <= 1'b0;
      end else if (cfg_we && (cfg_index == REG_ON_TIME)) begin
        on_time <= cfg_data[ON_TIME_W-1:0];
      end
    end
  end

endmodule

FILE: src/cplx_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cplx_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
